/* design/kmed_pkg.sv */
// ----------------------------------------------------------------------------
// kmed_pkg
// Shared widths, reset values and control/status types for the eager
// per-key debounce of a scanned key matrix.
// ----------------------------------------------------------------------------
package kmed_pkg;

    localparam int FIELD_W = 48;   // raw and stable key vectors
    localparam int STAMP_W = 32;   // millisecond timestamp
    localparam int TIMER_W = 8;    // per-key lockout counter

    localparam int ROWS_DEFAULT = 8;
    localparam int COLS_DEFAULT = 6;

    localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = TIMER_W'(5);
    localparam logic [TIMER_W-1:0] ELAPSED_SAT    = '1;

    // Common control sent to every key cell
    typedef struct packed {
        logic               commit;    // item moves to the result register
        logic               age_en;    // counters run down this item
        logic [TIMER_W-1:0] elapsed;   // saturated elapsed time
        logic [TIMER_W-1:0] reload;    // lockout length on a flip
    } cell_ctrl_t;

    // Status returned by each key cell
    typedef struct packed {
        logic expired;     // nonzero counter reaches zero this item
        logic remaining;   // counter still above zero after aging
        logic idle;        // counter is zero after aging
    } cell_stat_t;

endpackage

/* design/kmed_age.sv */
// ----------------------------------------------------------------------------
// kmed_age
// Elapsed time since the last stamp, modulo 2^32, saturated at the counter
// maximum.
// ----------------------------------------------------------------------------
module kmed_age
    import kmed_pkg::*;
(
    input  logic [STAMP_W-1:0] now_ms,
    input  logic [STAMP_W-1:0] last_stamp,
    output logic [TIMER_W-1:0] elapsed
);

    logic [STAMP_W-1:0] diff;

    assign diff    = now_ms - last_stamp;
    // saturate when any bit above the counter width is set
    assign elapsed = (|diff[STAMP_W-1:TIMER_W]) ? ELAPSED_SAT : diff[TIMER_W-1:0];

endmodule

/* design/kmed_key_cell.sv */
// ----------------------------------------------------------------------------
// kmed_key_cell
// Lockout counter of one key: ages by the elapsed time and reloads on a flip.
// ----------------------------------------------------------------------------
module kmed_key_cell
    import kmed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       load,
    output cell_stat_t stat
);

    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [TIMER_W-1:0] aged;
    logic               busy;
    logic               runs_out;

    assign busy     = (timer_reg != '0);
    assign runs_out = (timer_reg <= ctrl.elapsed);

    always_comb begin
        aged = timer_reg;
        if (ctrl.age_en && busy) begin
            aged = runs_out ? '0 : (timer_reg - ctrl.elapsed);
        end
    end

    assign stat.expired   = ctrl.age_en && busy && runs_out;
    assign stat.remaining = ctrl.age_en && busy && !runs_out;
    assign stat.idle      = (aged == '0);

    assign timer_next = load ? ctrl.reload : aged;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
        end else if (ctrl.commit) begin
            timer_reg <= timer_next;
        end
    end

endmodule

/* design/key_matrix_eager_debounce.sv */
// ----------------------------------------------------------------------------
// key_matrix_eager_debounce
// Eager, symmetric per-key debounce of a full ROWS x COLS matrix scan.
//
//   channel   ports                              width   direction
//   s_        s_valid/s_ready, s_raw_keys,        48      in
//             s_now_ms                            32      in
//   m_        m_valid/m_ready, m_stable_keys_out  48      out
//   cfg_      cfg_valid/cfg_ready, cfg_data       8       in (debounce time)
//
// One scan per cycle sustained while the result drains. A scan is captured
// in the input register, evaluated there by the per-key cells and lands in
// the result register. Reset is synchronous, active low, and clears all
// counters, flags and the debounce time to 5 ms. A stalled result holds;
// the input register keeps taking scans as long as the result register
// drains or is empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module key_matrix_eager_debounce
    import kmed_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_raw_keys,
    input  logic [STAMP_W-1:0] s_now_ms,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_stable_keys_out,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TIMER_W-1:0] cfg_data
);

    // Keys past the field width are not debounced
    localparam int NKEYS = ROWS * COLS;
    localparam int LIVE  = (NKEYS < FIELD_W) ? NKEYS : FIELD_W;

    // ---- configuration ------------------------------------------------------
    logic [TIMER_W-1:0] debounce_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_data;
        end
    end

    // ---- input register -----------------------------------------------------
    logic               in_valid_reg;
    logic [FIELD_W-1:0] in_raw_reg;
    logic [STAMP_W-1:0] in_now_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_keys_reg;
    logic               advance;

    // move the held scan on whenever the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_raw_reg <= s_raw_keys;
            in_now_reg <= s_now_ms;
        end
    end

    // ---- debounce state -----------------------------------------------------
    logic [FIELD_W-1:0] stable_reg;
    logic [FIELD_W-1:0] last_raw_reg;
    logic [STAMP_W-1:0] last_stamp_reg;
    logic               timers_pending_reg;
    logic               refresh_pending_reg;

    logic [TIMER_W-1:0] elapsed;
    logic               aging;
    logic               any_expired;
    logic               any_remaining;
    logic               refresh_mid;
    logic               pending_mid;
    logic               changed;
    logic               evaluate;
    logic [FIELD_W-1:0] flip;
    logic [FIELD_W-1:0] stable_next;
    logic [STAMP_W-1:0] last_stamp_next;
    logic               timers_pending_next;

    cell_ctrl_t         ctrl;
    cell_stat_t         stat [LIVE];

    kmed_age u_age (
        .now_ms     (in_now_reg),
        .last_stamp (last_stamp_reg),
        .elapsed    (elapsed)
    );

    // counters run only while some lockout is pending and time has passed
    assign aging = timers_pending_reg && (elapsed != '0);

    assign ctrl.commit  = advance;
    assign ctrl.age_en  = aging;
    assign ctrl.elapsed = elapsed;
    assign ctrl.reload  = debounce_reg;

    genvar k;
    generate
        for (k = 0; k < LIVE; k++) begin : g_key
            kmed_key_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .load    (flip[k]),
                .stat    (stat[k])
            );
            // flip at once when the raw bit differs and no lockout is running
            assign flip[k] = evaluate && (in_raw_reg[k] ^ stable_reg[k]) && stat[k].idle;
        end
        if (LIVE < FIELD_W) begin : g_unused
            assign flip[FIELD_W-1:LIVE] = '0;
        end
    endgenerate

    always_comb begin
        any_expired   = 1'b0;
        any_remaining = 1'b0;
        for (int i = 0; i < LIVE; i++) begin
            any_expired   = any_expired   | stat[i].expired;
            any_remaining = any_remaining | stat[i].remaining;
        end
    end

    // aging rewrites both flags; otherwise they carry over
    assign refresh_mid = aging ? any_expired   : refresh_pending_reg;
    assign pending_mid = aging ? any_remaining : timers_pending_reg;

    assign changed  = (in_raw_reg != last_raw_reg);
    assign evaluate = changed || refresh_mid;

    assign stable_next         = stable_reg ^ flip;
    assign timers_pending_next = pending_mid || (|flip);
    assign last_stamp_next     = (timers_pending_reg || evaluate) ? in_now_reg
                                                                  : last_stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg          <= '0;
            last_raw_reg        <= '0;
            last_stamp_reg      <= '0;
            timers_pending_reg  <= 1'b0;
            refresh_pending_reg <= 1'b0;
        end else if (advance) begin
            stable_reg          <= stable_next;
            last_raw_reg        <= in_raw_reg;
            last_stamp_reg      <= last_stamp_next;
            timers_pending_reg  <= timers_pending_next;
            refresh_pending_reg <= refresh_mid;
        end
    end

    // ---- result register ----------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_keys_reg <= stable_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_stable_keys_out = out_keys_reg;

endmodule

/* design/kmed_checker.sv */
// ----------------------------------------------------------------------------
// kmed_checker
// Port-level checks of the debounce block over time, bound to the top level.
// ----------------------------------------------------------------------------
module kmed_checker
    import kmed_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_stable_keys_out
);

    // reset leaves no result behind
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result always stems from an earlier scan transfer into the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching scan transfer");

    // a draining output never blocks the input side
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stable_keys_out))
        else $error("stalled result changed");

endmodule

bind key_matrix_eager_debounce kmed_checker u_kmed_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_stable_keys_out (m_stable_keys_out)
);

/* verif/key_matrix_eager_debounce_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_eager_debounce_test
// Self-checking bench for the eager per-key matrix debounce. A queue-fed
// driver sends full raw scans with millisecond stamps, and an in-bench model
// of the lockout counters predicts every debounced matrix. A monitor checks
// each result in order. Random gaps on both channels and several lockout
// settings, extremes and zero included, run between drained phases.
// ----------------------------------------------------------------------------
module key_matrix_eager_debounce_test;
    import kmed_pkg::*;

    localparam int KEYS           = ROWS_DEFAULT * COLS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_SCANS    = 238;

    typedef struct packed {
        logic [FIELD_W-1:0] raw;
        logic [STAMP_W-1:0] stamp;
    } key_scan_t;

    // Clock, reset and block ports; every input starts at a known value
    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_raw_keys        = '0;
    logic [STAMP_W-1:0] s_now_ms          = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [FIELD_W-1:0] m_stable_keys_out;
    logic               cfg_valid         = 1'b0;
    logic               cfg_ready;
    logic [TIMER_W-1:0] cfg_data          = '0;

    // Scans waiting to be sent and debounced matrices waiting to come back
    key_scan_t          scan_queue[$];
    logic [FIELD_W-1:0] stable_expect[$];

    // Debounce state as the block should hold it
    logic [TIMER_W-1:0] debounce_len;
    logic [FIELD_W-1:0] stable_keys;
    logic [FIELD_W-1:0] last_raw;
    logic [TIMER_W-1:0] key_timer[KEYS];
    logic [STAMP_W-1:0] last_stamp;
    logic               timers_busy;
    logic               expiry_seen;

    // Stimulus state: keys as a finger holds them, chattering contacts, clock
    logic [FIELD_W-1:0] physical_keys;
    logic [FIELD_W-1:0] bounce_mask;
    logic [STAMP_W-1:0] clock_ms;

    int        send_gap_max;
    int        recv_gap_max;
    int        send_wait;
    int        recv_wait;
    int        recv_stall;
    int        idle_cycles;
    int        mismatch_count;
    key_scan_t next_scan;

    key_matrix_eager_debounce i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_keys        (s_raw_keys),
        .s_now_ms          (s_now_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_stable_keys_out (m_stable_keys_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advance the debounce state by one accepted scan and queue the matrix
    // that the block must return for it.
    function automatic void debounce_scan(input logic [FIELD_W-1:0] raw,
                                          input logic [STAMP_W-1:0] now);
        logic               changed;
        logic               stamped;
        logic [STAMP_W-1:0] diff;
        logic [TIMER_W-1:0] elapsed;
        changed  = (raw != last_raw);
        stamped  = 1'b0;
        last_raw = raw;
        // Age the counters only while one of them is running
        if (timers_busy) begin
            diff       = now - last_stamp;
            last_stamp = now;
            stamped    = 1'b1;
            elapsed    = (diff > STAMP_W'(ELAPSED_SAT)) ? ELAPSED_SAT : diff[TIMER_W-1:0];
            // Zero elapsed time leaves counters and both flags alone
            if (elapsed != '0) begin
                timers_busy = 1'b0;
                expiry_seen = 1'b0;
                for (int k = 0; k < KEYS; k++) begin
                    if (key_timer[k] != '0) begin
                        if (key_timer[k] <= elapsed) begin
                            key_timer[k] = '0;
                            expiry_seen  = 1'b1;
                        end else begin
                            key_timer[k] = key_timer[k] - elapsed;
                            timers_busy  = 1'b1;
                        end
                    end
                end
            end
        end
        // Re-evaluate on a raw change or after an expiry; the expiry flag
        // stays up until a later scan ages the counters by a nonzero time
        if (changed || expiry_seen) begin
            if (!stamped) begin
                last_stamp = now;
            end
            for (int k = 0; k < KEYS; k++) begin
                if (raw[k] != stable_keys[k] && key_timer[k] == '0) begin
                    key_timer[k]   = debounce_len;
                    timers_busy    = 1'b1;
                    stable_keys[k] = ~stable_keys[k];
                end
            end
        end
        stable_expect.push_back(stable_keys);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_keys();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[FIELD_W-1:0];
    endfunction

    task automatic queue_scan(input logic [FIELD_W-1:0] raw, input logic [STAMP_W-1:0] stamp);
        key_scan_t scan;
        scan.raw   = raw;
        scan.stamp = stamp;
        scan_queue.push_back(scan);
    endtask

    // Mostly real typing: a few keys change per scan, freshly moved keys
    // chatter for a while, and the clock ticks a few ms. Mix in long idle
    // jumps (saturated and wrapping elapsed time) and pure noise scans.
    task automatic queue_random_scans(input int count);
        key_scan_t scan;
        int        pick;
        int        key_idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                repeat ($urandom_range(0, 2)) begin
                    key_idx                = $urandom_range(0, KEYS - 1);
                    physical_keys[key_idx] = ~physical_keys[key_idx];
                    bounce_mask[key_idx]   = 1'b1;
                end
                clock_ms    = clock_ms + STAMP_W'($urandom_range(0, 3));
                scan.raw    = physical_keys ^ (bounce_mask & rand_keys());
                bounce_mask = bounce_mask & (rand_keys() | rand_keys());
            end else if (pick < 84) begin
                clock_ms = clock_ms + STAMP_W'($urandom_range(200, 320));
                scan.raw = physical_keys;
            end else if (pick < 90) begin
                clock_ms = clock_ms + $urandom;
                scan.raw = physical_keys;
            end else begin
                clock_ms = clock_ms + STAMP_W'($urandom_range(0, 12));
                scan.raw = rand_keys();
            end
            scan.stamp = clock_ms;
            scan_queue.push_back(scan);
        end
    endtask

    // Hold until every scan is sent and every result is back, then let the
    // two-stage pipeline settle before anything else happens.
    task automatic wait_drained();
        while (scan_queue.size() != 0 || s_valid || stable_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Write the lockout length; call only at a rising edge with the block idle
    task automatic write_debounce(input logic [TIMER_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        debounce_len = value;
        cfg_valid <= 1'b0;
    endtask

    // Scan driver: predict on each transfer, then either hold the current
    // scan, idle out the drawn gap, or present the next pending scan.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                debounce_scan(s_raw_keys, s_now_ms);
            end
            if (s_valid && !s_ready) begin
                // hold valid and payload until the transfer
            end else if (send_wait != 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (scan_queue.size() != 0) begin
                next_scan  = scan_queue.pop_front();
                s_valid    <= 1'b1;
                s_raw_keys <= next_scan.raw;
                s_now_ms   <= next_scan.stamp;
                send_wait  <= $urandom_range(0, send_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, then
    // stall ready for a freshly drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (stable_expect.size() == 0) begin
                $display("%0t: unexpected result, actual %012h", $time, m_stable_keys_out);
                mismatch_count++;
            end else if (stable_expect[0] !== m_stable_keys_out) begin
                $display("%0t: stable keys mismatch, expected %012h, actual %012h",
                         $time, stable_expect[0], m_stable_keys_out);
                mismatch_count++;
                void'(stable_expect.pop_front());
            end else begin
                void'(stable_expect.pop_front());
            end
            recv_stall = $urandom_range(0, recv_gap_max);
            m_ready   <= (recv_stall == 0);
            recv_wait <= (recv_stall == 0) ? 0 : recv_stall - 1;
        end else if (recv_wait != 0) begin
            m_ready   <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: drop the run if no channel has a transfer for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, stable_expect.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [TIMER_W-1:0] phase_debounce[PHASES];
        int                 phase_send_gap[PHASES];
        int                 phase_recv_gap[PHASES];

        // Mirror the reset state of the block
        debounce_len   = DEBOUNCE_RESET;
        stable_keys    = '0;
        last_raw       = '0;
        last_stamp     = '0;
        timers_busy    = 1'b0;
        expiry_seen    = 1'b0;
        for (int k = 0; k < KEYS; k++) begin
            key_timer[k] = '0;
        end
        physical_keys  = '0;
        bounce_mask    = '0;
        idle_cycles    = 0;
        mismatch_count = 0;
        send_gap_max   = 8;
        recv_gap_max   = 8;

        // Lockout settings: both extremes, zero (no lockout), reset value
        phase_debounce = '{8'd1, 8'd255, 8'd0, TIMER_W'($urandom_range(2, 254)),
                           DEBOUNCE_RESET, 8'd255};
        phase_send_gap = '{8, 0, 8, 0, 8, 3};
        phase_recv_gap = '{8, 0, 0, 8, 8, 3};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed scans at the reset lockout of 5 ms
        queue_scan('0, 32'd0);                            // nothing moves
        queue_scan('1, 32'd1);                            // every key presses at once
        queue_scan('0, 32'd1);                            // zero elapsed: all locked
        queue_scan('0, 32'd3);                            // partial run-down
        queue_scan('0, 32'd8);                            // expiry releases every key
        queue_scan('0, 32'd8);                            // zero elapsed, expiry flag kept
        queue_scan(48'hAAAA_AAAA_AAAA, 32'd9);
        queue_scan(48'h5555_5555_5555, 32'd10);           // bounce against lockout
        queue_scan(48'h5555_5555_5555, 32'd300);          // saturated elapsed
        queue_scan(48'h5555_5555_5555, 32'd300);
        queue_scan(48'h8000_0000_0000, 32'hFFFF_FFFE);    // top key only
        queue_scan(48'h8000_0000_0000, 32'h0000_0003);    // stamp wraps
        queue_scan(48'h0000_0000_0001, 32'h0000_0004);    // bottom key only
        queue_scan(48'h0000_0000_0001, 32'h0000_0104);    // elapsed 256 saturates
        queue_scan(48'h0000_0000_0001, 32'h0000_0203);    // elapsed exactly 255
        queue_scan('1, 32'hFFFF_FFFF);
        queue_scan('0, 32'h8000_0000);
        queue_scan('0, 32'h8000_0005);
        clock_ms = 32'h8000_0005;

        // Each phase starts from an empty pipeline, which also makes the
        // sender pause until every result is back
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_debounce(phase_debounce[p]);
            send_gap_max = phase_send_gap[p];
            recv_gap_max = phase_recv_gap[p];
            queue_random_scans(PHASE_SCANS);
        end
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* key_matrix_eager_debounce.f */
design/kmed_pkg.sv
design/kmed_age.sv
design/kmed_key_cell.sv
design/key_matrix_eager_debounce.sv
design/kmed_checker.sv
verif/key_matrix_eager_debounce_test.sv
